### src/tpg_pkg.sv
// shared constants, types and the cordic angle table of the two-axis guidance block
package tpg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_CW      = $clog2(CORDIC_STEPS);
    localparam int CIN_W        = 36;
    localparam int CW           = 38;
    localparam int ZW           = 34;
    localparam int DIV_NW       = 37;
    localparam int DIV_DW       = 16;
    localparam int DIV_CW       = $clog2(DIV_NW + 1);

    localparam logic signed [20:0] PI_Q16       = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q16   = 21'sd411775;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [29:0] KINV_Q30     = 30'd652032874;
    localparam logic [26:0] DEG2RAD_Q32  = 27'd74961321;
    localparam logic [16:0] MIN_AUTH_Q16 = 17'd6554;
    localparam logic [16:0] FULL_AUTH    = 17'd65536;
    localparam logic [38:0] MIN_GROUND_Q8 = 39'd12800;
    localparam logic signed [19:0] DEADZONE_Q16 = 20'sd66;
    localparam logic signed [51:0] CMD_MAX = 52'sd262143;
    localparam logic signed [51:0] CMD_MIN = -52'sd262144;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_INTEG_LIM  = 3'd3,
        CFG_TURN_RATE  = 3'd4,
        CFG_BEST_SPEED = 3'd5
    } cfg_index_t;

    // arctangent of 2^-i in q4.30
    function automatic logic [ZW-1:0] atan_q30(input logic [4:0] i);
        logic [ZW-1:0] r;
        unique case (i)
            5'd0:    r = 34'd843314857;
            5'd1:    r = 34'd497837829;
            5'd2:    r = 34'd263043837;
            5'd3:    r = 34'd133525159;
            5'd4:    r = 34'd67021687;
            5'd5:    r = 34'd33543516;
            5'd6:    r = 34'd16775851;
            5'd7:    r = 34'd8388437;
            5'd8:    r = 34'd4194283;
            5'd9:    r = 34'd2097149;
            default: r = 34'd1 << (5'd30 - i);
        endcase
        return r;
    endfunction

endpackage

### src/tpg_div.sv
// restoring unsigned divider, one quotient bit per cycle
module tpg_div
    import tpg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] q_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   trial;
    logic              ge;

    assign trial = {rem_reg, q_reg[DIV_NW-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### src/tpg_cordic.sv
// vectoring cordic, one micro-rotation per cycle, gives angle and scaled length
module tpg_cordic
    import tpg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [CIN_W-1:0] x_in,
    input  logic signed [CIN_W-1:0] y_in,
    output logic                    done,
    output logic signed [19:0]      angle,
    output logic [CW-1:0]           mag_x
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_CW-1:0]       cnt_reg;
    logic signed [CW-1:0]     x_reg;
    logic signed [CW-1:0]     y_reg;
    logic signed [ZW-1:0]     z_reg;
    logic signed [CW-1:0]     xe;
    logic signed [CW-1:0]     ye;
    logic signed [CW-1:0]     xs;
    logic signed [CW-1:0]     ys;
    logic signed [ZW-1:0]     a;
    logic signed [ZW-1:0]     zr;

    assign xe = CW'(x_in);
    assign ye = CW'(y_in);
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign a  = atan_q30(5'(cnt_reg));
    assign zr = z_reg + ZW'(8192);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= !(x_in == '0 && y_in == '0);
            done_reg <= (x_in == '0 && y_in == '0);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == STEP_CW'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (x_in == '0 && y_in == '0)
            begin
                x_reg <= '0;
                y_reg <= '0;
                z_reg <= '0;
            end
            else if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg <= ye;
                    y_reg <= -xe;
                    z_reg <= HALF_PI_Q30;
                end
                else
                begin
                    x_reg <= -ye;
                    y_reg <= xe;
                    z_reg <= -HALF_PI_Q30;
                end
            end
            else
            begin
                x_reg <= xe;
                y_reg <= ye;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + a;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - a;
            end
        end
    end

    assign done  = done_reg;
    assign angle = zr[ZW-1:14];
    assign mag_x = x_reg;

endmodule

### src/two_axis_pid_guidance_top.sv
// two-axis pid guidance: sequencer, shared multiplier, pid state and ports
//
//  channel  | handshake            | content
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_ready  | own and aim position, speed, attitude, dt
//  out      | out_valid / out_ready| yaw and pitch step, yaw and pitch error
//  cfg      | cfg_valid / cfg_ready| register index and write data
//
// one item runs up to three division waits (authority, skipped when the best
// speed register is zero, and the derivative of each axis, skipped when
// step_time is zero), two cordic passes and the sequencer states around
// the shared 33x33 multiplier.
// reset clears registers, integrators, last errors and the held target.
// in_ready is high only while idle; a finished result waits in the output
// register and the next item may be taken while it waits.
module two_axis_pid_guidance_top
    import tpg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] own_x,
    input  logic signed [31:0] own_y,
    input  logic signed [31:0] own_z,
    input  logic               aim_valid,
    input  logic signed [31:0] aim_x,
    input  logic signed [31:0] aim_y,
    input  logic signed [31:0] aim_z,
    input  logic [15:0]        own_speed,
    input  logic signed [18:0] own_heading,
    input  logic signed [18:0] own_pitch,
    input  logic [15:0]        step_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [18:0] yaw_step,
    output logic signed [18:0] pitch_step,
    output logic signed [18:0] yaw_err_out,
    output logic signed [19:0] pitch_err_out,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_AUTH, S_AUTH_W, S_TR1, S_TR2, S_TR3, S_TR4, S_CY,
        S_KA, S_KB, S_KC, S_CP, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_DONE
    } state_t;

    state_t state_reg;

    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic [30:0]        lim_reg;
    logic [7:0]         turn_reg;
    logic [15:0]        best_reg;

    logic signed [31:0] own_x_reg, own_y_reg, own_z_reg;
    logic signed [31:0] held_x_reg, held_y_reg, held_z_reg;
    logic [15:0]        spd_reg;
    logic signed [18:0] head_reg, pit_reg;
    logic [15:0]        dt_reg;

    logic [16:0]        auth_reg;
    logic [19:0]        step_reg;
    logic signed [19:0] dyaw_reg;
    logic [CW-1:0]      xm_reg;
    logic [46:0]        kacc_reg;
    logic signed [19:0] yerr_reg, perr_reg;
    logic               ax_reg;
    logic signed [31:0] a_reg, d_reg;
    logic signed [51:0] sum_reg;
    logic               dneg_reg;
    logic signed [18:0] ycmd_reg, pcmd_reg;
    logic signed [31:0] yaw_accum_reg, pitch_accum_reg;
    logic signed [19:0] last_yaw_reg, last_pitch_reg;

    logic               out_valid_reg;
    logic signed [18:0] yaw_step_reg, pitch_step_reg, yaw_err_reg;
    logic signed [19:0] pitch_err_reg;

    logic                    div_go_reg;
    logic [DIV_NW-1:0]       div_num_reg;
    logic [DIV_DW-1:0]       div_den_reg;
    logic                    div_done;
    logic [DIV_NW-1:0]       div_q;
    logic                    cor_go_reg;
    logic signed [CIN_W-1:0] cx_reg, cy_reg;
    logic                    cor_done;
    logic signed [19:0]      cor_angle;
    logic [CW-1:0]           cor_mag;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    // derived values
    logic signed [32:0] dx, dy, dz;
    logic [15:0]        spd_lo, spd_hi;
    logic [68:0]        ktotal;
    logic [38:0]        mag;
    logic [38:0]        gnd;
    logic signed [20:0] ye0, ywrap;
    logic signed [20:0] pe0;
    logic signed [19:0] err, last;
    logic signed [31:0] acc, acc_eff;
    logic signed [20:0] inc;
    logic signed [32:0] a_sum, lim33;
    logic signed [31:0] a_next;
    logic signed [20:0] diff;
    logic [20:0]        diff_mag;
    logic signed [31:0] d_sat;
    logic signed [49:0] term;
    logic signed [51:0] total, stp, v1, v2;
    logic signed [18:0] cmd;

    assign dx = 33'(held_x_reg) - 33'(own_x_reg);
    assign dy = 33'(held_y_reg) - 33'(own_y_reg);
    assign dz = 33'(held_z_reg) - 33'(own_z_reg);
    assign spd_lo = (spd_reg < best_reg) ? spd_reg : best_reg;
    assign spd_hi = (spd_reg < best_reg) ? best_reg : spd_reg;

    assign ktotal = {prod_reg[50:0], 17'd0} + 69'(kacc_reg);
    assign mag    = ktotal[68:30];
    assign gnd    = (mag < MIN_GROUND_Q8) ? MIN_GROUND_Q8 : mag;

    assign ye0   = 21'(dyaw_reg) - 21'(head_reg);
    assign ywrap = (ye0 > PI_Q16) ? ye0 - TWO_PI_Q16 :
                   (ye0 < -PI_Q16) ? ye0 + TWO_PI_Q16 : ye0;
    assign pe0   = 21'(cor_angle) - 21'(pit_reg);

    assign err  = ax_reg ? perr_reg : yerr_reg;
    assign last = ax_reg ? last_pitch_reg : last_yaw_reg;
    assign acc  = ax_reg ? pitch_accum_reg : yaw_accum_reg;
    assign acc_eff = ((err > 0 && last < 0) || (err < 0 && last > 0)) ? '0 : acc;
    assign inc   = prod_reg[36:16];
    assign lim33 = {2'b00, lim_reg};
    assign a_sum = 33'(acc_eff) + 33'(inc);
    assign a_next = (a_sum > lim33) ? lim33[31:0] :
                    (a_sum < -lim33) ? 32'(-lim33) : a_sum[31:0];

    assign diff     = 21'(err) - 21'(last);
    assign diff_mag = diff[20] ? 21'(-diff) : diff;
    assign d_sat = dneg_reg ?
                   ((div_q > 37'd2147483648) ? 32'sh80000000 : 32'(-div_q[31:0])) :
                   ((div_q > 37'd2147483647) ? 32'sh7FFFFFFF : div_q[31:0]);

    assign term  = prod_reg[65:16];
    assign total = (err < DEADZONE_Q16 && err > -DEADZONE_Q16) ? '0 : sum_reg + 52'(term);
    assign stp   = {32'd0, step_reg};
    assign v1    = (total > stp) ? stp : (total < -stp) ? -stp : total;
    assign v2    = (v1 > CMD_MAX) ? CMD_MAX : (v1 < CMD_MIN) ? CMD_MIN : v1;
    assign cmd   = v2[18:0];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_TR1:
            begin
                mul_a = {25'd0, turn_reg};
                mul_b = {16'd0, auth_reg};
            end
            S_TR2:
            begin
                mul_a = {8'd0, prod_reg[24:0]};
                mul_b = {6'd0, DEG2RAD_Q32};
            end
            S_TR3:
            begin
                mul_a = {13'd0, prod_reg[51:32]};
                mul_b = {17'd0, dt_reg};
            end
            S_KA:
            begin
                mul_a = {16'd0, xm_reg[16:0]};
                mul_b = {3'd0, KINV_Q30};
            end
            S_KB:
            begin
                mul_a = {12'd0, xm_reg[CW-1:17]};
                mul_b = {3'd0, KINV_Q30};
            end
            S_P0:
            begin
                mul_a = 33'(err);
                mul_b = {17'd0, dt_reg};
            end
            S_P3:
            begin
                mul_a = 33'(kp_reg);
                mul_b = 33'(err);
            end
            S_P4:
            begin
                mul_a = 33'(ki_reg);
                mul_b = 33'(a_reg);
            end
            S_P5:
            begin
                mul_a = 33'(kd_reg);
                mul_b = 33'(d_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            lim_reg  <= '0;
            turn_reg <= '0;
            best_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  kp_reg   <= cfg_data;
                CFG_INTEG_GAIN: ki_reg   <= cfg_data;
                CFG_DERIV_GAIN: kd_reg   <= cfg_data;
                CFG_INTEG_LIM:  lim_reg  <= cfg_data[30:0];
                CFG_TURN_RATE:  turn_reg <= cfg_data[7:0];
                CFG_BEST_SPEED: best_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            div_go_reg      <= 1'b0;
            cor_go_reg      <= 1'b0;
            held_x_reg      <= '0;
            held_y_reg      <= '0;
            held_z_reg      <= '0;
            yaw_accum_reg   <= '0;
            pitch_accum_reg <= '0;
            last_yaw_reg    <= '0;
            last_pitch_reg  <= '0;
            ax_reg          <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            cor_go_reg <= 1'b0;
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        own_x_reg <= own_x;
                        own_y_reg <= own_y;
                        own_z_reg <= own_z;
                        spd_reg   <= own_speed;
                        head_reg  <= own_heading;
                        pit_reg   <= own_pitch;
                        dt_reg    <= step_time;
                        if (aim_valid)
                        begin
                            held_x_reg <= aim_x;
                            held_y_reg <= aim_y;
                            held_z_reg <= aim_z;
                        end
                        state_reg <= S_AUTH;
                    end
                end
                S_AUTH:
                begin
                    if (best_reg == '0)
                    begin
                        auth_reg  <= FULL_AUTH;
                        state_reg <= S_TR1;
                    end
                    else
                    begin
                        div_num_reg <= {5'd0, spd_lo, 16'd0};
                        div_den_reg <= spd_hi;
                        div_go_reg  <= 1'b1;
                        state_reg   <= S_AUTH_W;
                    end
                end
                S_AUTH_W:
                begin
                    if (div_done)
                    begin
                        auth_reg  <= (div_q < 37'(MIN_AUTH_Q16)) ? MIN_AUTH_Q16 : div_q[16:0];
                        state_reg <= S_TR1;
                    end
                end
                S_TR1: state_reg <= S_TR2;
                S_TR2: state_reg <= S_TR3;
                S_TR3: state_reg <= S_TR4;
                S_TR4:
                begin
                    step_reg   <= prod_reg[35:16];
                    cx_reg     <= CIN_W'(dx);
                    cy_reg     <= CIN_W'(dy);
                    cor_go_reg <= 1'b1;
                    state_reg  <= S_CY;
                end
                S_CY:
                begin
                    if (cor_done)
                    begin
                        dyaw_reg  <= cor_angle;
                        xm_reg    <= cor_mag;
                        state_reg <= S_KA;
                    end
                end
                S_KA: state_reg <= S_KB;
                S_KB:
                begin
                    kacc_reg  <= prod_reg[46:0];
                    state_reg <= S_KC;
                end
                S_KC:
                begin
                    cx_reg     <= {1'b0, gnd[CIN_W-2:0]};
                    cy_reg     <= CIN_W'(dz);
                    cor_go_reg <= 1'b1;
                    state_reg  <= S_CP;
                end
                S_CP:
                begin
                    if (cor_done)
                    begin
                        yerr_reg  <= ywrap[19:0];
                        perr_reg  <= pe0[19:0];
                        ax_reg    <= 1'b0;
                        state_reg <= S_P0;
                    end
                end
                S_P0: state_reg <= S_P1;
                S_P1:
                begin
                    a_reg <= a_next;
                    if (ax_reg)
                    begin
                        pitch_accum_reg <= a_next;
                    end
                    else
                    begin
                        yaw_accum_reg <= a_next;
                    end
                    if (dt_reg != '0)
                    begin
                        div_num_reg <= {diff_mag, 16'd0};
                        div_den_reg <= dt_reg;
                        div_go_reg  <= 1'b1;
                        dneg_reg    <= diff[20];
                        state_reg   <= S_P2;
                    end
                    else
                    begin
                        d_reg     <= '0;
                        state_reg <= S_P3;
                    end
                end
                S_P2:
                begin
                    if (div_done)
                    begin
                        d_reg     <= d_sat;
                        state_reg <= S_P3;
                    end
                end
                S_P3: state_reg <= S_P4;
                S_P4:
                begin
                    sum_reg   <= 52'(term);
                    state_reg <= S_P5;
                end
                S_P5:
                begin
                    sum_reg   <= sum_reg + 52'(term);
                    state_reg <= S_P6;
                end
                S_P6:
                begin
                    if (ax_reg)
                    begin
                        last_pitch_reg <= err;
                        pcmd_reg       <= cmd;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        last_yaw_reg <= err;
                        ycmd_reg     <= cmd;
                        ax_reg       <= 1'b1;
                        state_reg    <= S_P0;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        yaw_step_reg   <= ycmd_reg;
                        pitch_step_reg <= pcmd_reg;
                        yaw_err_reg    <= yerr_reg[18:0];
                        pitch_err_reg  <= perr_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    tpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    tpg_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_go_reg),
        .x_in  (cx_reg),
        .y_in  (cy_reg),
        .done  (cor_done),
        .angle (cor_angle),
        .mag_x (cor_mag)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign yaw_step      = yaw_step_reg;
    assign pitch_step    = pitch_step_reg;
    assign yaw_err_out   = yaw_err_reg;
    assign pitch_err_out = pitch_err_reg;

    // a transfer in makes the block busy on the next cycle
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a divider start is never followed directly by a completion report
    a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
        div_go_reg |=> !div_done)
        else $error("divider start overlaps completion");

    // the cordic start is only seen while the sequencer waits in S_CY or S_CP
    a_cor_go: assert property (@(posedge clk) disable iff (!rst_n)
        cor_go_reg |-> (state_reg == S_CY || state_reg == S_CP))
        else $error("cordic started out of sequence");

endmodule

### verif/tb.sv
// self-checking testbench for two_axis_pid_guidance_top, with its own guidance predictor
`timescale 1ns / 100ps

module tb;
    import tpg_pkg::*;

    typedef struct {
        logic signed [31:0] own_x, own_y, own_z;
        logic               aim_valid;
        logic signed [31:0] aim_x, aim_y, aim_z;
        logic [15:0]        own_speed;
        logic signed [18:0] own_heading, own_pitch;
        logic [15:0]        step_time;
    } guid_item_t;

    typedef struct {
        logic signed [18:0] yaw_step, pitch_step, yaw_err;
        logic signed [19:0] pitch_err;
    } guid_cmd_t;

    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid, in_ready, out_valid, out_ready;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = CFG_PROP_GAIN;
    logic [31:0] cfg_data = '0;
    logic signed [18:0] yaw_step, pitch_step, yaw_err_out;
    logic signed [19:0] pitch_err_out;
    guid_item_t cur = '{default: '0};

    guid_item_t pending_items[$];
    guid_cmd_t  expected_cmds[$];
    int  send_idle = 0, rx_stall = 0, error_count = 0;
    bit  hold_send = 0, holdoff_start = 0, holdoff_used = 0;
    int  holdoff_left = 0;
    longint cycles = 0;

    // guidance state and registers
    longint p_gain, i_gain, d_gain, i_limit, rate_deg, best_spd;
    longint yaw_acc, pitch_acc, last_yerr, last_perr, tgt_x, tgt_y, tgt_z;

    two_axis_pid_guidance_top u_dut (
        .clk, .rst_n, .in_valid, .in_ready,
        .own_x(cur.own_x), .own_y(cur.own_y), .own_z(cur.own_z),
        .aim_valid(cur.aim_valid), .aim_x(cur.aim_x), .aim_y(cur.aim_y), .aim_z(cur.aim_z),
        .own_speed(cur.own_speed), .own_heading(cur.own_heading),
        .own_pitch(cur.own_pitch), .step_time(cur.step_time),
        .out_valid, .out_ready, .yaw_step, .pitch_step, .yaw_err_out, .pitch_err_out,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint vector_angle(longint x, longint y, output longint mag);
        longint z, t, a;
        z = 0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            return 0;
        end
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 1686629713;
            end
            else
            begin
                t = x; x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 30; i++)
        begin
            case (i)
                0: a = 843314857;
                1: a = 497837829;
                2: a = 263043837;
                3: a = 133525159;
                4: a = 67021687;
                5: a = 33543516;
                6: a = 16775851;
                7: a = 8388437;
                8: a = 4194283;
                9: a = 2097149;
                default: a = longint'(1) << (30 - i);
            endcase
            if (y > 0)
            begin
                t = x + (y >>> i); y = y - (x >>> i); z += a;
            end
            else
            begin
                t = x - (y >>> i); y = y + (x >>> i); z -= a;
            end
            x = t;
        end
        mag = (x * 652032874) >>> 30;
        return (z + 8192) >>> 14;
    endfunction

    function automatic longint pid_term(longint err, inout longint acc, inout longint last,
                                        input longint dt);
        longint a, d, sum, d_min, d_max;
        d_max = 2147483647;
        d_min = -d_max - 1;
        if ((err > 0 && last < 0) || (err < 0 && last > 0))
            acc = 0;
        a = acc + ((err * dt) >>> 16);
        if (a > i_limit) a = i_limit;
        if (a < -i_limit) a = -i_limit;
        acc = a;
        d = 0;
        if (dt != 0) d = ((err - last) * 65536) / dt;
        if (d > d_max) d = d_max;
        if (d < d_min) d = d_min;
        sum = ((p_gain * err) >>> 16) + ((i_gain * a) >>> 16) + ((d_gain * d) >>> 16);
        last = err;
        if (err < 66 && err > -66) sum = 0;
        return sum;
    endfunction

    function automatic longint clamp_cmd(longint v, longint lim);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        if (v > 262143) v = 262143;
        if (v < -262144) v = -262144;
        return v;
    endfunction

    function automatic guid_cmd_t predict_guidance(guid_item_t it);
        guid_cmd_t r;
        longint auth, lo, hi, rate, lim, g, spare, dyaw, dpitch, yerr, perr, dt;
        dt = it.step_time;
        if (it.aim_valid)
        begin
            tgt_x = it.aim_x; tgt_y = it.aim_y; tgt_z = it.aim_z;
        end
        if (best_spd == 0)
            auth = 65536;
        else
        begin
            lo = (it.own_speed < best_spd) ? it.own_speed : best_spd;
            hi = (it.own_speed < best_spd) ? best_spd : it.own_speed;
            auth = (lo << 16) / hi;
        end
        if (auth < 6554) auth = 6554;
        rate = (rate_deg * auth * 74961321) >> 32;
        lim = (rate * dt) >> 16;
        dyaw = vector_angle(tgt_x - it.own_x, tgt_y - it.own_y, g);
        if (g < 12800) g = 12800;
        dpitch = vector_angle(g, tgt_z - it.own_z, spare);
        yerr = dyaw - it.own_heading;
        while (yerr > 205887) yerr -= 411775;
        while (yerr < -205887) yerr += 411775;
        perr = dpitch - it.own_pitch;
        r.yaw_step = 19'(clamp_cmd(pid_term(yerr, yaw_acc, last_yerr, dt), lim));
        r.pitch_step = 19'(clamp_cmd(pid_term(perr, pitch_acc, last_perr, dt), lim));
        r.yaw_err = 19'(yerr);
        r.pitch_err = 20'(perr);
        return r;
    endfunction

    function automatic guid_item_t rand_item(bit near);
        guid_item_t it;
        it.own_x = $urandom; it.own_y = $urandom; it.own_z = $urandom;
        it.aim_x = $urandom; it.aim_y = $urandom; it.aim_z = $urandom;
        if (near)
        begin
            it.own_x = $signed(it.own_x) >>> 6; it.own_y = $signed(it.own_y) >>> 6;
            it.own_z = $signed(it.own_z) >>> 10;
            it.aim_x = it.own_x + ($signed($urandom) >>> $urandom_range(10, 20));
            it.aim_y = it.own_y + ($signed($urandom) >>> $urandom_range(10, 20));
            it.aim_z = it.own_z + ($signed($urandom) >>> $urandom_range(14, 24));
        end
        it.aim_valid = ($urandom_range(0, 3) != 0);
        it.own_speed = 16'($urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            it.own_heading = 19'($urandom); it.own_pitch = 19'($urandom);
        end
        else
        begin
            it.own_heading = 19'($urandom_range(0, 411774) - 205887);
            it.own_pitch = 19'($urandom_range(0, 411774) - 205887);
        end
        it.step_time = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 255))
                                                  : 16'($urandom_range(1, 65535));
        return it;
    endfunction

    function automatic guid_item_t make_item(longint ox, longint oy, longint oz, bit av,
                                             longint ax, longint ay, longint az, longint spd,
                                             longint hd, longint pt, longint dt);
        guid_item_t it;
        it.own_x = 32'(ox); it.own_y = 32'(oy); it.own_z = 32'(oz); it.aim_valid = av;
        it.aim_x = 32'(ax); it.aim_y = 32'(ay); it.aim_z = 32'(az);
        it.own_speed = 16'(spd);
        it.own_heading = 19'(hd); it.own_pitch = 19'(pt); it.step_time = 16'(dt);
        return it;
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                expected_cmds.push_back(predict_guidance(cur));
            if (!(in_valid && !in_ready))
            begin
                if (pending_items.size() > 0 && !hold_send
                    && $urandom_range(0, 99) >= send_idle)
                begin
                    cur <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end
                else
                begin
                    guid_cmd_t e;
                    e = expected_cmds.pop_front();
                    if (yaw_step !== e.yaw_step)
                    begin
                        $error("yaw_step exp %0d got %0d", e.yaw_step, yaw_step);
                        error_count++;
                    end
                    if (pitch_step !== e.pitch_step)
                    begin
                        $error("pitch_step exp %0d got %0d", e.pitch_step, pitch_step);
                        error_count++;
                    end
                    if (yaw_err_out !== e.yaw_err)
                    begin
                        $error("yaw_err_out exp %0d got %0d", e.yaw_err, yaw_err_out);
                        error_count++;
                    end
                    if (pitch_err_out !== e.pitch_err)
                    begin
                        $error("pitch_err_out exp %0d got %0d", e.pitch_err, pitch_err_out);
                        error_count++;
                    end
                end
            end
            out_ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= rx_stall);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (holdoff_start && !holdoff_used)
        begin
            holdoff_left <= 3000;
            holdoff_used <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PROP_GAIN:  p_gain = longint'($signed(data));
            CFG_INTEG_GAIN: i_gain = longint'($signed(data));
            CFG_DERIV_GAIN: d_gain = longint'($signed(data));
            CFG_INTEG_LIM:  i_limit = data[30:0];
            CFG_TURN_RATE:  rate_deg = data[7:0];
            CFG_BEST_SPEED: best_spd = data[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (!(pending_items.size() == 0 && !in_valid && expected_cmds.size() == 0))
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] pg, logic [31:0] ig, logic [31:0] dg,
                             logic [31:0] il, logic [31:0] tr, logic [31:0] bs);
        write_reg(CFG_PROP_GAIN, pg);
        write_reg(CFG_INTEG_GAIN, ig);
        write_reg(CFG_DERIV_GAIN, dg);
        write_reg(CFG_INTEG_LIM, il);
        write_reg(CFG_TURN_RATE, tr);
        write_reg(CFG_BEST_SPEED, bs);
    endtask

    initial
    begin
        p_gain = 0; i_gain = 0; d_gain = 0; i_limit = 0; rate_deg = 0; best_spd = 0;
        yaw_acc = 0; pitch_acc = 0; last_yerr = 0; last_perr = 0;
        tgt_x = 0; tgt_y = 0; tgt_z = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  rx_stall = 0;  end
                1: begin send_idle = 47; rx_stall = 0;  end
                2: begin send_idle = 0;  rx_stall = 47; end
                default: begin send_idle = 10; rx_stall = 10; end
            endcase
            case (ph)
                1: write_all(32'd65536, 32'd16384, 32'd4096, 32'd262144, 32'd90, 32'd200);
                2: write_all(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                             32'd255, 32'd0);
                3: write_all(-32'sd196608, 32'd131072, -32'sd2000, 32'd0, 32'd255,
                             32'd65535);
                4: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: ;
            endcase
            if (ph == 1)
            begin
                // directed corners
                pending_items.push_back(make_item(0, 0, 0, 1, 0, 0, 0, 100, 0, 0, 1000));
                pending_items.push_back(make_item(100, 200, 300, 1, 100, 200, 300, 0,
                                                  205887, -205887, 65535));
                pending_items.push_back(make_item(0, 0, 0, 1, 25600, 0, 0, 65535, 0, 0, 0));
                pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 50, -262144, 262143,
                                                  500));
                pending_items.push_back(make_item(0, 0, 0, 1, 0, 12800, 0, 200, 262143,
                                                  -262144, 1));
                pending_items.push_back(make_item(-2147483648, -2147483648, -2147483648, 1,
                                                  2147483647, 2147483647, 2147483647,
                                                  65535, 0, 0, 65535));
                pending_items.push_back(make_item(2147483647, 2147483647, 2147483647, 1,
                                                  -2147483648, -2147483648, -2147483648,
                                                  1, 205887, 205887, 65535));
                pending_items.push_back(make_item(0, 0, 0, 1, -25600, 100, 0, 300, 0, 0,
                                                  4000));
                pending_items.push_back(make_item(0, 0, 0, 1, -25600, -100, 0, 300, 0, 0,
                                                  4000));
                pending_items.push_back(make_item(0, 0, 0, 1, 0, -25600, 5000, 300, 0, 0,
                                                  4000));
                pending_items.push_back(make_item(5, 5, 5, 0, -1, -1, -1, 300, 0, 0, 0));
                pending_items.push_back(make_item(0, 0, 0, 1, 25600, 40, 0, 200, 0, 0,
                                                  65535));
                holdoff_start = 1;
            end
            for (int n = 0; n < (ph == 0 ? 150 : 420); n++)
            begin
                pending_items.push_back(rand_item($urandom_range(0, 3) != 0));
                if (ph == 2 && n == 200)
                begin
                    // sender pause until all results are back
                    while (!(pending_items.size() == 0 && !in_valid
                             && expected_cmds.size() == 0))
                        @(posedge clk);
                end
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
src/tpg_pkg.sv
src/tpg_div.sv
src/tpg_cordic.sv
src/two_axis_pid_guidance_top.sv
verif/tb.sv
